// File: src/sosk_pkg.sv
// Package for the SOS Kawasaki Metropolis step core.
// Constants, register map, sequencer codes and word layouts; no dependencies.
package sosk_pkg;

   // default geometry
   localparam int SITES_DEF        = 512;
   localparam int HEIGHT_LIMIT_DEF = 800;
   localparam int HEIGHT_W         = 10;

   // field widths
   localparam int SITE_W   = 9;
   localparam int RAND_W   = 32;
   localparam int BETA_W   = 20;
   localparam int FIELD_W  = 24;
   localparam int DE_W     = 15;
   localparam int DEOUT_W  = 14;
   localparam int TOTAL_W  = 29;
   localparam int ENERGY_W = 33;
   localparam int PROD_W   = BETA_W + 1 + ENERGY_W;

   // word layouts
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   // energy total saturation
   localparam logic [TOTAL_W-1:0] ENERGY_MAX = TOTAL_W'(400000000);

   // exp argument cutoff (Q.16)
   localparam int EXP_ARG_LIMIT = 23;

   // reciprocal multipliers for truncating division by 5 and by 3
   localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;  // shift 34
   localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;  // shift 33
   localparam logic [31:0] Q31_ONE = 32'h8000_0000;

   // register map
   localparam int CSR_AW = 3;
   localparam logic REG_BETA  = 1'b0;
   localparam logic REG_FIELD = 1'b1;
   localparam logic [BETA_W-1:0]  BETA_RESET  = BETA_W'(16384);
   localparam logic [FIELD_W-1:0] FIELD_RESET = '0;

   // read order of the four heights
   localparam logic [1:0] RD_HN  = 2'd0;
   localparam logic [1:0] RD_HX  = 2'd1;
   localparam logic [1:0] RD_HXP = 2'd2;
   localparam logic [1:0] RD_HNP = 2'd3;

   // exp micro-steps on the shared multiplier
   localparam logic [3:0] EXP_DIV5  = 4'd0;
   localparam logic [3:0] EXP_DIV4  = 4'd1;
   localparam logic [3:0] EXP_PROD3 = 4'd2;
   localparam logic [3:0] EXP_DIV3  = 4'd3;
   localparam logic [3:0] EXP_DIV2  = 4'd4;
   localparam logic [3:0] EXP_DIV1  = 4'd5;
   localparam logic [3:0] EXP_SQ_LAST = 4'd13;

endpackage

// File: src/sos_kawasaki_metropolis_step_core.sv
// SOS Kawasaki Metropolis step core: height ring in one RAM, one move per word.
// Path from request accept to result: a bounds reject ends after the height reads,
// a beta*E past the exp cutoff rejects after the decide state, a beta*E that is not
// positive accepts at once, and otherwise the exp weight is evaluated (14 steps of one
// shared 32x32 multiplier). A new request is accepted in the cycle after the result is
// registered; a later result waits in DONE while the previous one is not taken.
// After reset a clearing pass writes every address once, loading each height with
// HEIGHT_LIMIT/2 before the first request is taken; the CSRs work meanwhile.
// Depends on sosk_pkg and sosk_ram.
module sos_kawasaki_metropolis_step_core #(
   parameter int SITES        = sosk_pkg::SITES_DEF,
   parameter int HEIGHT_LIMIT = sosk_pkg::HEIGHT_LIMIT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: site_index[8:0], move_direction[9], random_fraction[41:10]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sosk_pkg::REQ_DATA_W-1:0]   req_tdata,
   // result: move_accepted[0], energy_change[14:1], energy_total[43:15]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sosk_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // CSR port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sosk_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import sosk_pkg::*;

   localparam int AW        = $clog2(SITES);
   localparam int MOD_SHIFT = 22;
   localparam int MOD_RECIP = ((1 << MOD_SHIFT) + SITES - 1) / SITES;
   localparam logic [HEIGHT_W-1:0] HEIGHT_HALF = HEIGHT_W'(HEIGHT_LIMIT / 2);
   localparam logic [HEIGHT_W-1:0] HEIGHT_TOP  = HEIGHT_W'(HEIGHT_LIMIT - 1);

   // sequencer states
   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_MOD0   = 4'd2;
   localparam logic [3:0] ST_MOD1   = 4'd3;
   localparam logic [3:0] ST_READ   = 4'd4;
   localparam logic [3:0] ST_CALC   = 4'd5;
   localparam logic [3:0] ST_MUL    = 4'd6;
   localparam logic [3:0] ST_TEST   = 4'd7;
   localparam logic [3:0] ST_EXP    = 4'd8;
   localparam logic [3:0] ST_DECIDE = 4'd9;
   localparam logic [3:0] ST_WR1    = 4'd10;
   localparam logic [3:0] ST_WR2    = 4'd11;
   localparam logic [3:0] ST_DONE   = 4'd12;

   logic [3:0]              state_ff, state_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [2:0]              rd_cnt_ff, rd_cnt_in;
   logic [3:0]              step_ff, step_in;

   logic [SITE_W-1:0]       site_ff, site_in;
   logic                    dir_ff, dir_in;
   logic [RAND_W-1:0]       rnd_ff, rnd_in;
   logic [7:0]              q_ff, q_in;
   logic [AW-1:0]           x_ff, x_in;
   logic [HEIGHT_W-1:0]     h_ff [4];
   logic signed [DE_W-1:0]  de_ff, de_in;
   logic signed [ENERGY_W-1:0] energy_ff, energy_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [31:0]             u_ff, u_in;
   logic [31:0]             t_ff, t_in;
   logic [31:0]             n_ff, n_in;
   logic                    acc_ff, acc_in;

   logic [BETA_W-1:0]       beta_ff, beta_in;
   logic [FIELD_W-1:0]      field_ff, field_in;
   logic [TOTAL_W-1:0]      sum_ff, sum_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // RAM port
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [HEIGHT_W-1:0]     wr_data;
   logic [AW-1:0]           rd_addr;
   logic [HEIGHT_W-1:0]     rd_data;

   // ring neighbors of x
   logic [AW-1:0] a_plus1, a_minus1, a_plus2, a_minus2;
   logic [AW-1:0] a_hn, a_hxp, a_hnp;
   logic [AW:0]   x_wide;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   logic [29:0] mod_prod;
   logic        csr_wr;
   logic        can_load;
   logic signed [TOTAL_W+1:0] total;
   logic [DEOUT_W-1:0] de_sat;

   sosk_ram #(
      .WIDTH (HEIGHT_W),
      .DEPTH (SITES)
   ) u_heights (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // neighbor addresses
   always_comb begin
      x_wide   = {1'b0, x_ff};
      a_plus1  = (x_ff == AW'(SITES - 1)) ? '0 : AW'(x_wide + 1'b1);
      a_minus1 = (x_ff == '0) ? AW'(SITES - 1) : AW'(x_wide - 1'b1);
      a_plus2  = ((x_wide + 2'd2) >= (AW + 1)'(SITES)) ?
                 AW'(x_wide + 2'd2 - (AW + 1)'(SITES)) : AW'(x_wide + 2'd2);
      a_minus2 = (x_wide < 2'd2) ?
                 AW'(x_wide + (AW + 1)'(SITES) - 2'd2) : AW'(x_wide - 2'd2);
      a_hn     = dir_ff ? a_minus1 : a_plus1;
      a_hxp    = dir_ff ? a_plus1  : a_minus1;
      a_hnp    = dir_ff ? a_plus2  : a_minus2;
   end

   // RAM access
   always_comb begin
      unique case (rd_cnt_ff[1:0])
         RD_HN:   rd_addr = a_hn;
         RD_HX:   rd_addr = x_ff;
         RD_HXP:  rd_addr = a_hxp;
         default: rd_addr = a_hnp;
      endcase
      wr_en   = 1'b0;
      wr_addr = x_ff;
      wr_data = h_ff[RD_HX] + 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = HEIGHT_HALF;
         end
         ST_WR1: begin
            wr_en = 1'b1;
         end
         ST_WR2: begin
            wr_en   = 1'b1;
            wr_addr = a_hxp;
            wr_data = h_ff[RD_HXP] - 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // exp operand select
   always_comb begin
      mul_a = u_ff;
      mul_b = t_ff;
      unique case (step_ff)
         EXP_DIV5: begin
            mul_b = RECIP5;
         end
         EXP_DIV3: begin
            mul_a = n_ff;
            mul_b = RECIP3;
         end
         EXP_DIV4, EXP_PROD3, EXP_DIV2, EXP_DIV1: begin
            mul_b = t_ff;
         end
         default: begin
            mul_a = t_ff;
         end
      endcase
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   assign mod_prod = 30'(site_ff) * 30'(MOD_RECIP);
   assign can_load = !rsp_valid_ff || rsp_tready;

   // energy total update and output saturation
   always_comb begin
      total = $signed({2'b00, sum_ff}) + (TOTAL_W + 2)'(de_ff);
      if (de_ff > $signed(DE_W'(8191))) begin
         de_sat = DEOUT_W'(8191);
      end else if (de_ff < -$signed(DE_W'(8192))) begin
         de_sat = {1'b1, {(DEOUT_W - 1){1'b0}}};
      end else begin
         de_sat = de_ff[DEOUT_W-1:0];
      end
   end

   // CSR writes
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   always_comb begin
      beta_in  = beta_ff;
      field_in = field_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_BETA:  beta_in  = csr_pwdata[BETA_W-1:0];
            default:   field_in = csr_pwdata[FIELD_W-1:0];
         endcase
      end
   end
   always_comb begin
      unique case (csr_paddr[2])
         REG_BETA:  csr_prdata = 32'(beta_ff);
         default:   csr_prdata = 32'(field_ff);
      endcase
   end

   // main sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rd_cnt_in    = rd_cnt_ff;
      step_in      = step_ff;
      site_in      = site_ff;
      dir_in       = dir_ff;
      rnd_in       = rnd_ff;
      q_in         = q_ff;
      x_in         = x_ff;
      de_in        = de_ff;
      energy_in    = energy_ff;
      prod_in      = prod_ff;
      u_in         = u_ff;
      t_in         = t_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = AW'(clr_ff + 1'b1);
            if (clr_ff == AW'(SITES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               site_in  = req_tdata[SITE_W-1:0];
               dir_in   = req_tdata[SITE_W];
               rnd_in   = req_tdata[SITE_W+RAND_W:SITE_W+1];
               state_in = ST_MOD0;
            end
         end
         // site modulo SITES by reciprocal
         ST_MOD0: begin
            q_in     = mod_prod[29:22];
            state_in = ST_MOD1;
         end
         ST_MOD1: begin
            x_in      = AW'(32'(site_ff) - 32'(q_ff) * 32'(SITES));
            rd_cnt_in = '0;
            state_in  = ST_READ;
         end
         // four reads, each read's data captured in the cycle after its address
         ST_READ: begin
            rd_cnt_in = rd_cnt_ff + 1'b1;
            if (rd_cnt_ff == 3'd4) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            acc_in = 1'b0;
            de_in  = DE_W'(2 * ($signed({5'b0, h_ff[RD_HX]}) - $signed({5'b0, h_ff[RD_HN]}))
                   + 4 * ($signed({5'b0, h_ff[RD_HX]}) - $signed({5'b0, h_ff[RD_HXP]}))
                   - 2 * ($signed({5'b0, h_ff[RD_HXP]}) - $signed({5'b0, h_ff[RD_HNP]}))
                   + 6);
            if (h_ff[RD_HX] >= HEIGHT_TOP || h_ff[RD_HXP] <= HEIGHT_W'(1)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            energy_in = dir_ff ?
               $signed({{2{de_ff[DE_W-1]}}, de_ff, 16'b0})
                 + $signed({{(ENERGY_W - FIELD_W){field_ff[FIELD_W-1]}}, field_ff}) :
               $signed({{2{de_ff[DE_W-1]}}, de_ff, 16'b0})
                 - $signed({{(ENERGY_W - FIELD_W){field_ff[FIELD_W-1]}}, field_ff});
            state_in = ST_TEST;
         end
         ST_TEST: begin
            prod_in  = $signed({1'b0, beta_ff}) * energy_ff;
            state_in = ST_DECIDE;
            step_in  = EXP_DIV5;
         end
         ST_DECIDE: begin
            // route on the sign and size of beta*E
            if (prod_ff[PROD_W-1] || prod_ff == '0) begin
               acc_in   = 1'b1;
               state_in = ST_WR1;
            end else if (prod_ff[PROD_W-2:16] >= (PROD_W - 17)'(EXP_ARG_LIMIT << 16)) begin
               state_in = ST_DONE;
            end else begin
               u_in     = {4'b0, prod_ff[36:16], 7'b0};
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            step_in = step_ff + 1'b1;
            unique case (step_ff)
               EXP_DIV5:  t_in = Q31_ONE - 32'(mul_p >> 34);
               EXP_DIV4:  t_in = Q31_ONE - 32'(mul_p >> 33);
               EXP_PROD3: n_in = 32'(mul_p >> 31);
               EXP_DIV3:  t_in = Q31_ONE - 32'(mul_p >> 33);
               EXP_DIV2:  t_in = Q31_ONE - 32'(mul_p >> 32);
               EXP_DIV1:  t_in = Q31_ONE - 32'(mul_p >> 31);
               default:   t_in = 32'(mul_p >> 31);
            endcase
            if (step_ff == EXP_SQ_LAST) begin
               state_in = ST_DONE;
               if ({1'b0, rnd_ff} < {32'(mul_p >> 31), 1'b0}) begin
                  acc_in   = 1'b1;
                  state_in = ST_WR1;
               end
            end
         end
         ST_WR1: begin
            state_in = ST_WR2;
         end
         ST_WR2: begin
            if (total[TOTAL_W+1]) begin
               sum_in = '0;
            end else if (total > $signed({2'b00, ENERGY_MAX})) begin
               sum_in = ENERGY_MAX;
            end else begin
               sum_in = total[TOTAL_W-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({sum_ff,
                                           acc_ff ? de_sat : {DEOUT_W{1'b0}},
                                           acc_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rd_cnt_ff    <= '0;
         step_ff      <= '0;
         acc_ff       <= 1'b0;
         sum_ff       <= '0;
         beta_ff      <= BETA_RESET;
         field_ff     <= FIELD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_cnt_ff    <= rd_cnt_in;
         step_ff      <= step_in;
         acc_ff       <= acc_in;
         sum_ff       <= sum_in;
         beta_ff      <= beta_in;
         field_ff     <= field_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      site_ff     <= site_in;
      dir_ff      <= dir_in;
      rnd_ff      <= rnd_in;
      q_ff        <= q_in;
      x_ff        <= x_in;
      de_ff       <= de_in;
      energy_ff   <= energy_in;
      prod_ff     <= prod_in;
      u_ff        <= u_in;
      t_ff        <= t_in;
      n_ff        <= n_in;
      rsp_data_ff <= rsp_data_in;
      if (state_ff == ST_READ && rd_cnt_ff != 3'd0) begin
         h_ff[2'(rd_cnt_ff - 1'b1)] <= rd_data;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: src/sosk_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Standalone; no package dependencies.
module sosk_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
